/* sv/ipsr_pkg.sv */
// ----------------------------------------------------------------------------
// ipsr_pkg
// Types and constants shared by the address set range query block.
// ----------------------------------------------------------------------------
package ipsr_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned AddrW      = 32;
  localparam int unsigned ModeW      = 3;

  typedef enum logic [ModeW-1:0] {
    MODE_INSERT    = 3'd0,
    MODE_REMOVE    = 3'd1,
    MODE_LOOKUP    = 3'd2,
    MODE_RANGE_ALL = 3'd3,
    MODE_RANGE_ANY = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_e;

  // Request held stable while the scan token walks the chain.
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [AddrW-1:0] lo;
    logic [AddrW-1:0] hi;
  } req_t;

  // Token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic            active;
    logic            any_free;
    logic [IdxW-1:0] free_idx;
    logic [CntW-1:0] count;
  } tok_t;

  // Write of a new entry at the end of an insert scan.
  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  idx;
    logic [AddrW-1:0] addr;
  } commit_t;

endpackage

/* sv/ipsr_in_if.sv */
// ----------------------------------------------------------------------------
// ipsr_in_if
// Request channel: valid/ready handshake with mode and two addresses.
// ----------------------------------------------------------------------------
interface ipsr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] addr_first;
  logic [31:0] addr_second;

  modport source (output valid, mode, addr_first, addr_second, input ready);
  modport sink   (input valid, mode, addr_first, addr_second, output ready);
endinterface

/* sv/ipsr_out_if.sv */
// ----------------------------------------------------------------------------
// ipsr_out_if
// Result channel: valid/ready handshake with hit and status.
// ----------------------------------------------------------------------------
interface ipsr_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic status;

  modport source (output valid, hit, status, input ready);
  modport sink   (input valid, hit, status, output ready);
endinterface

/* sv/ipsr_cell.sv */
// ----------------------------------------------------------------------------
// ipsr_cell
// One table slot: stores an address and a valid bit, updates the scan token.
// ----------------------------------------------------------------------------
module ipsr_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [ipsr_pkg::IdxW-1:0] idx_i,
  input  ipsr_pkg::req_t           req_i,
  input  ipsr_pkg::commit_t        commit_i,
  input  ipsr_pkg::tok_t           tok_i,
  output ipsr_pkg::tok_t           tok_o
);
  import ipsr_pkg::*;

  logic             valid_q;
  logic [AddrW-1:0] addr_q;
  tok_t             tok_q, tok_d;
  logic             in_range;

  assign in_range = valid_q && (addr_q >= req_i.lo) && (addr_q <= req_i.hi);

  always_comb begin
    tok_d = tok_i;
    if (in_range) begin
      tok_d.count = tok_i.count + CntW'(1);
    end
    if (!tok_i.any_free && !valid_q) begin
      tok_d.any_free = 1'b1;
      tok_d.free_idx = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      // For a remove, lo equals hi, so a slot in range holds the address.
      if (tok_i.active && req_i.mode == MODE_REMOVE && in_range) begin
        valid_q <= 1'b0;
      end else if (commit_i.we && commit_i.idx == idx_i) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i.we && commit_i.idx == idx_i) begin
      addr_q <= commit_i.addr;
    end
  end

  assign tok_o = tok_q;

endmodule

/* sv/ip_address_set_range_query_top.sv */
// ----------------------------------------------------------------------------
// ip_address_set_range_query_top
// IPv4 address set held in a chain of slot cells, with range queries.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload
// in_i    | in  | mode, addr_first, addr_second
// out_o   | out | hit, status
//
// After a request is accepted, a token walks the chain of slot cells one cell
// per cycle, then the result word is registered. One request is in flight at
// a time; a new request is taken the cycle after the result word has been
// taken. Reset clears all valid bits at once. A stalled result word holds
// until out_o.ready.
module ip_address_set_range_query_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  ipsr_in_if.sink    in_i,
  ipsr_out_if.source out_o
);
  import ipsr_pkg::*;

  state_e state_q, state_d;
  req_t   req_q;
  logic   start_q;
  logic   hit_q, status_q;
  logic   in_fire, done;
  tok_t   tok [TableDepth+1];
  tok_t   tail;
  commit_t commit;
  logic [AddrW:0] span;
  logic   hit_d, status_d;

  assign in_fire = in_i.valid && in_i.ready;
  assign tail    = tok[TableDepth];
  assign done    = tail.active;

  assign tok[0] = '{active: start_q, any_free: 1'b0, free_idx: '0, count: '0};

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    ipsr_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (IdxW'(g)),
      .req_i    (req_q),
      .commit_i (commit),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1])
    );
  end

  assign span = {1'b0, req_q.hi} - {1'b0, req_q.lo} + (AddrW+1)'(1);

  always_comb begin
    commit      = '0;
    commit.idx  = tail.free_idx;
    commit.addr = req_q.lo;
    hit_d       = 1'b0;
    status_d    = 1'b0;
    case (req_q.mode)
      MODE_INSERT: begin
        if (tail.count == '0) begin
          commit.we = done && tail.any_free;
          status_d  = !tail.any_free;
        end
      end
      MODE_LOOKUP, MODE_RANGE_ANY: hit_d = (tail.count != '0);
      MODE_RANGE_ALL: hit_d = ((AddrW+1)'(tail.count) == span);
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_i.valid) state_d = ST_SCAN;
      ST_SCAN: if (done) state_d = ST_OUT;
      ST_OUT:  if (out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready  = (state_q == ST_IDLE);
    out_o.valid = (state_q == ST_OUT);
    out_o.hit    = hit_q;
    out_o.status = status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_fire;
    end
  end

  // Non-range modes scan with lo equal to hi equal to the address.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q.mode <= in_i.mode;
      if (in_i.mode == MODE_RANGE_ALL || in_i.mode == MODE_RANGE_ANY) begin
        req_q.lo <= (in_i.addr_first < in_i.addr_second) ? in_i.addr_first
                                                         : in_i.addr_second;
        req_q.hi <= (in_i.addr_first < in_i.addr_second) ? in_i.addr_second
                                                         : in_i.addr_first;
      end else begin
        req_q.lo <= in_i.addr_first;
        req_q.hi <= in_i.addr_first;
      end
    end
    if (done) begin
      hit_q    <= hit_d;
      status_q <= status_d;
    end
  end

endmodule

/* sim/ipsr_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipsr_checker
// Watches both channels of the address set block, keeps its own copy of the
// set, predicts the hit and status of each request and compares them.
// ----------------------------------------------------------------------------
module ipsr_checker
  import ipsr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ipsr_in_if         in_i,
  ipsr_out_if        out_o,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic hit;
    logic status;
  } answer_t;

  logic [AddrW-1:0] slot_addr [TableDepth];
  logic             slot_used [TableDepth];
  answer_t          answer_q [$];
  int               fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = answer_q.size();

  function automatic int find_slot(logic [AddrW-1:0] addr);
    for (int i = 0; i < TableDepth; i++) begin
      if (slot_used[i] && slot_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  // Applies one request to the set and returns the answer it produces.
  function automatic answer_t apply_request(logic [ModeW-1:0] mode,
                                            logic [AddrW-1:0] a,
                                            logic [AddrW-1:0] b);
    answer_t          ans;
    logic [AddrW-1:0] lo;
    logic [AddrW-1:0] hi;
    longint unsigned  n;
    int               slot;
    ans  = '0;
    lo   = (a < b) ? a : b;
    hi   = (a < b) ? b : a;
    n    = 0;
    slot = find_slot(a);
    for (int i = 0; i < TableDepth; i++) begin
      if (slot_used[i] && slot_addr[i] >= lo && slot_addr[i] <= hi) n++;
    end
    case (mode)
      MODE_INSERT: begin
        if (slot < 0) begin
          ans.status = 1'b1;
          for (int i = 0; i < TableDepth; i++) begin
            if (!slot_used[i]) begin
              slot_addr[i] = a;
              slot_used[i] = 1'b1;
              ans.status   = 1'b0;
              break;
            end
          end
        end
      end
      MODE_REMOVE: begin
        if (slot >= 0) slot_used[slot] = 1'b0;
      end
      MODE_LOOKUP:    ans.hit = (slot >= 0);
      MODE_RANGE_ALL: ans.hit = (n == longint'(hi) - longint'(lo) + 1);
      MODE_RANGE_ANY: ans.hit = (n > 0);
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t got;
    answer_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TableDepth; i++) begin
        slot_used[i] = 1'b0;
        slot_addr[i] = '0;
      end
      answer_q.delete();
      fail_count <= 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        answer_q.push_back(apply_request(in_i.mode, in_i.addr_first, in_i.addr_second));
      end
      if (out_o.valid && out_o.ready) begin
        got.hit    = out_o.hit;
        got.status = out_o.status;
        if (answer_q.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result word: hit %0b status %0b",
                                        got.hit, got.status);
          fail_count <= fail_count + 1;
        end else begin
          want = answer_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("Mismatch: expected hit %0b status %0b, got hit %0b status %0b",
                       want.hit, want.status, got.hit, got.status);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives requests into the address set block with random gaps and result
// stalls; a checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_top;
  import ipsr_pkg::*;

  localparam int NumRandom = 90;
  localparam int CycleLimit = 600 * 300 * 4;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycle_count;
  logic calm;

  ipsr_in_if  in_if ();
  ipsr_out_if out_if ();

  ip_address_set_range_query_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  ipsr_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_o        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Result stalls; a calm stretch turns them off.
  always @(posedge clk_i) begin
    out_if.ready <= calm || ($urandom_range(99) >= 31);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Small pool of addresses so that queries hit.
  logic [AddrW-1:0] pool [16];

  function automatic logic [AddrW-1:0] pick_addr();
    if ($urandom_range(9) < 7) return pool[$urandom_range(15)];
    return $urandom();
  endfunction

  // Valid stays high after an accept until the next word or an idle cycle
  // replaces it, so back-to-back words see a single assignment per edge.
  task automatic send(logic [ModeW-1:0] mode, logic [AddrW-1:0] a, logic [AddrW-1:0] b);
    while (!calm && $urandom_range(99) < 31) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.mode        <= mode;
    in_if.addr_first  <= a;
    in_if.addr_second <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  initial begin
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] a;
    int               m;
    cycle_count       = 0;
    calm              = 1'b0;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.mode        = '0;
    in_if.addr_first  = '0;
    in_if.addr_second = '0;
    out_if.ready      = 1'b0;
    for (int i = 0; i < 16; i++) pool[i] = (i < 8) ? 32'hC0A8_0000 + i : $urandom();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every mode, duplicates, absent removes, equal bounds.
    send(MODE_LOOKUP, 32'h0, 32'h0);
    send(MODE_INSERT, 32'h0, 32'hFFFF_FFFF);
    send(MODE_INSERT, 32'hFFFF_FFFF, 32'h0);
    send(MODE_INSERT, 32'h0, 32'h0);
    send(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send(MODE_RANGE_ALL, 32'h0, 32'h0);
    send(MODE_RANGE_ALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(MODE_RANGE_ALL, 32'hFFFF_FFFF, 32'h0);
    send(MODE_RANGE_ANY, 32'hFFFF_FFFF, 32'h0);
    send(MODE_RANGE_ANY, 32'h1, 32'hFFFF_FFFE);
    send(MODE_REMOVE, 32'h1234_5678, 32'h0);
    send(MODE_REMOVE, 32'h0, 32'h0);
    send(MODE_RANGE_ANY, 32'h0, 32'h0);
    for (int i = 0; i < 4; i++) send(MODE_INSERT, 32'hC0A8_0000 + i, $urandom());
    send(MODE_RANGE_ALL, 32'hC0A8_0003, 32'hC0A8_0000);
    send(MODE_RANGE_ALL, 32'hC0A8_0000, 32'hC0A8_0004);
    send(MODE_RANGE_ANY, 32'hC0A8_0004, 32'hC0A8_0010);
    send(3'd5, 32'hC0A8_0000, 32'hC0A8_0000);
    send(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(3'd7, 32'h0, 32'hFFFF_FFFF);

    // Fill the table past its capacity, then query and drain part of it.
    base = $urandom();
    for (int i = 0; i < TableDepth + 2; i++) send(MODE_INSERT, base + i, $urandom());
    send(MODE_INSERT, $urandom(), 32'h0);
    send(MODE_RANGE_ALL, base, base + 100);
    send(MODE_RANGE_ANY, base - 5, base);
    for (int i = 0; i < 16; i++) send(MODE_REMOVE, base + $urandom_range(TableDepth + 1), 32'h0);
    for (int i = 0; i < 60; i++) send(MODE_REMOVE, base + i, 32'h0);

    // Random mix; a stretch from the first third to the half runs without gaps or stalls.
    for (int n = 0; n < NumRandom; n++) begin
      calm = (n > NumRandom / 3 && n < NumRandom / 2);
      m = $urandom_range(99);
      a = pick_addr();
      if (m < 35) send(MODE_INSERT, a, $urandom());
      else if (m < 50) send(MODE_REMOVE, a, $urandom());
      else if (m < 65) send(MODE_LOOKUP, a, $urandom());
      else if (m < 80) send(MODE_RANGE_ALL, a, a + $urandom_range(3) - 1);
      else if (m < 95) send(MODE_RANGE_ANY, a, ($urandom_range(3) == 0) ? $urandom() : a + $urandom_range(8));
      else send(3'($urandom_range(7)), a, $urandom());
    end
    calm = 1'b0;
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
